// ===== rtl/sdlp_pkg.sv =====
// Shared types, widths and register indexes of the stereo delay low-pass panner.
`timescale 1ns / 1ps

package sdlp_pkg;

    localparam int SAMPLE_W        = 16;
    localparam int STATE_W         = SAMPLE_W + 8;
    localparam int DELAY_W         = 8;
    localparam int COEF_W          = 16;
    localparam int COEF_FRAC       = 15;
    localparam int GAIN_W          = 16;
    localparam int CFG_IDX_W       = 3;
    localparam int CFG_DATA_W      = 16;
    localparam int DELAY_DEPTH_DEF = 256;

    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_LEFT   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_RIGHT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DELAY_LEFT  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DELAY_RIGHT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_LEFT   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_RIGHT  = 3'd5;

    localparam logic signed [GAIN_W-1:0] GAIN_RESET  = 16'sh7FFF;
    localparam logic [DELAY_W-1:0]       DELAY_RESET = 8'd0;
    localparam logic [COEF_W-1:0]        COEF_ONE    = 16'h8000;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] left_sample;
        logic signed [SAMPLE_W-1:0] right_sample;
    } t_in_beat;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] left_out;
        logic signed [SAMPLE_W-1:0] right_out;
    } t_out_beat;

    typedef struct packed {
        logic accept;
        logic diff_en;
        logic mac_en;
        logic gain_en;
    } t_lane_ctl;

endpackage

// ===== rtl/sdlp_lane.sv =====
// One channel lane: delay line memory, one-pole low-pass filter and gain stage.
`timescale 1ns / 1ps

module sdlp_lane #(
    parameter int DELAY_DEPTH = sdlp_pkg::DELAY_DEPTH_DEF
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  sdlp_pkg::t_lane_ctl                     i_ctl,
    input  logic signed [sdlp_pkg::SAMPLE_W-1:0]    i_sample,
    input  logic [$clog2(DELAY_DEPTH)-1:0]          i_wr_addr,
    input  logic [$clog2(DELAY_DEPTH+1)-1:0]        i_fill,
    input  logic [sdlp_pkg::DELAY_W-1:0]            i_delay,
    input  logic [sdlp_pkg::COEF_W-1:0]             i_coef,
    input  logic signed [sdlp_pkg::GAIN_W-1:0]      i_gain,
    output logic signed [sdlp_pkg::SAMPLE_W-1:0]    o_y
);

    localparam int AW    = $clog2(DELAY_DEPTH);
    localparam int FW    = $clog2(DELAY_DEPTH + 1);
    localparam int DLW   = (AW > sdlp_pkg::DELAY_W) ? AW : sdlp_pkg::DELAY_W;
    localparam int SW    = sdlp_pkg::SAMPLE_W;
    localparam int STW   = sdlp_pkg::STATE_W;
    localparam int DW    = STW + 1;
    localparam int CW    = sdlp_pkg::COEF_W + 1;
    localparam int PW    = DW + CW;
    localparam int PSW   = PW - sdlp_pkg::COEF_FRAC;
    localparam int SUMW  = PSW + 1;
    localparam int SCW   = STW + sdlp_pkg::GAIN_W;
    localparam int QW    = SCW - STW + 1;

    localparam logic [AW:0]    DEPTH_V   = (AW + 1)'(DELAY_DEPTH);
    localparam logic [DLW-1:0] DMAX_V    = DLW'(DELAY_DEPTH - 1);
    localparam logic signed [STW-1:0] ST_MAX = {1'b0, {(STW - 1){1'b1}}};
    localparam logic signed [STW-1:0] ST_MIN = {1'b1, {(STW - 1){1'b0}}};
    localparam logic signed [SW-1:0]  SMP_MAX = {1'b0, {(SW - 1){1'b1}}};
    localparam logic signed [SW-1:0]  SMP_MIN = {1'b1, {(SW - 1){1'b0}}};

    logic [SW-1:0] r_mem [DELAY_DEPTH];

    logic [DLW-1:0] delay_ext;
    logic [AW-1:0]  d_eff;
    logic [AW-1:0]  rd_addr;
    logic           hit;

    logic signed [SW-1:0]   r_x;
    logic [SW-1:0]          r_rd;
    logic                   r_bypass;
    logic                   r_hit;
    logic signed [DW-1:0]   r_diff;
    logic signed [STW-1:0]  r_state;
    logic signed [SCW-1:0]  r_scaled;

    logic signed [SW-1:0]   tap;
    logic signed [DW-1:0]   n_diff;
    logic signed [CW-1:0]   coef_c;
    logic signed [PW-1:0]   prod;
    logic signed [PSW-1:0]  prod_sh;
    logic signed [SUMW-1:0] sum;
    logic signed [STW-1:0]  n_state;
    logic signed [QW-1:0]   q;

    always_comb begin
        delay_ext = DLW'(i_delay);
        if (delay_ext > DMAX_V) begin
            d_eff = AW'(DELAY_DEPTH - 1);
        end else begin
            d_eff = delay_ext[AW-1:0];
        end
        if (i_wr_addr >= d_eff) begin
            rd_addr = i_wr_addr - d_eff;
        end else begin
            rd_addr = AW'({1'b0, i_wr_addr} + DEPTH_V - {1'b0, d_eff});
        end
        hit = (FW'(d_eff) <= i_fill);
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.accept) begin
            r_mem[i_wr_addr] <= i_sample;
            r_rd             <= r_mem[rd_addr];
            r_x              <= i_sample;
            r_bypass         <= (d_eff == '0);
            r_hit            <= hit;
        end
    end

    always_comb begin
        if (r_bypass) begin
            tap = r_x;
        end else if (r_hit) begin
            tap = r_rd;
        end else begin
            tap = '0;
        end
        n_diff = {tap[SW-1], tap, {(STW - SW){1'b0}}} - {r_state[STW-1], r_state};
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.diff_en) begin
            r_diff <= n_diff;
        end
    end

    always_comb begin
        if (i_coef > sdlp_pkg::COEF_ONE) begin
            coef_c = {1'b0, sdlp_pkg::COEF_ONE};
        end else begin
            coef_c = {1'b0, i_coef};
        end
        prod    = r_diff * coef_c;
        prod_sh = prod[PW-1:sdlp_pkg::COEF_FRAC];
        sum     = {{(SUMW - STW){r_state[STW-1]}}, r_state} + {prod_sh[PSW-1], prod_sh};
        if ((&sum[SUMW-1:STW-1]) || !(|sum[SUMW-1:STW-1])) begin
            n_state = sum[STW-1:0];
        end else if (sum[SUMW-1]) begin
            n_state = ST_MIN;
        end else begin
            n_state = ST_MAX;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '0;
        end else if (i_ctl.mac_en) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.gain_en) begin
            r_scaled <= r_state * i_gain;
        end
    end

    always_comb begin
        q = r_scaled[SCW-1:STW-1];
        if ((&q[QW-1:SW-1]) || !(|q[QW-1:SW-1])) begin
            o_y = q[SW-1:0];
        end else if (q[QW-1]) begin
            o_y = SMP_MIN;
        end else begin
            o_y = SMP_MAX;
        end
    end

endmodule

// ===== rtl/sdlp_merge.sv =====
// Output stage that joins the two lane results into one registered beat.
`timescale 1ns / 1ps

module sdlp_merge (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_load,
    input  logic signed [sdlp_pkg::SAMPLE_W-1:0] i_left,
    input  logic signed [sdlp_pkg::SAMPLE_W-1:0] i_right,
    output logic                                 o_free,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output sdlp_pkg::t_out_beat                  o_out_data
);

    logic                r_valid;
    sdlp_pkg::t_out_beat r_data;

    assign o_free = !r_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_data.left_out  <= i_left;
            r_data.right_out <= i_right;
        end
    end

    assign o_out_valid = r_valid;
    assign o_out_data  = r_data;

endmodule

// ===== rtl/stereo_delay_lowpass_panner.sv =====
// Top level of the stereo delay, low-pass and gain panner.
`timescale 1ns / 1ps

// Each input beat is one stereo frame; each output beat is the processed frame.
// Both channels use valid and stall; a beat moves when valid is high and stall low.
// The left and right lanes run in lockstep: each writes its sample into its own
// delay line, reads the delayed sample, updates its one-pole filter and applies
// its gain. The output register then holds the joined result.
// The read, difference, filter update and gain steps of each lane run one after
// another; a new frame is taken only once the lanes are done with the last one.
// When the output register is still full and stalled, the lanes hold their
// finished result and the input stays stalled until the output beat is taken.
// Configuration is written through the plain write port while the block is idle;
// this is a rule for the user, which the block itself does not enforce.
// Reset is synchronous and active low. It restores the register defaults,
// clears the filter state and the write position, and empties the output.
// The delay lines are not swept: a fill count makes entries not yet written
// since reset read as zero, so the block takes input in the first cycle
// after reset.

module stereo_delay_lowpass_panner #(
    parameter int DELAY_DEPTH = sdlp_pkg::DELAY_DEPTH_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_in_valid,
    output logic                                   o_in_stall,
    input  sdlp_pkg::t_in_beat                     i_in_data,
    output logic                                   o_out_valid,
    input  logic                                   i_out_stall,
    output sdlp_pkg::t_out_beat                    o_out_data,
    input  logic                                   i_cfg_wr_en,
    input  logic [sdlp_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [sdlp_pkg::CFG_DATA_W-1:0]        i_cfg_data
);

    localparam int AW = $clog2(DELAY_DEPTH);
    localparam int FW = $clog2(DELAY_DEPTH + 1);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_DIFF = 5'b00010,
        S_MAC  = 5'b00100,
        S_GAIN = 5'b01000,
        S_DONE = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;

    logic signed [sdlp_pkg::GAIN_W-1:0] r_gain_left;
    logic signed [sdlp_pkg::GAIN_W-1:0] r_gain_right;
    logic [sdlp_pkg::DELAY_W-1:0]       r_delay_left;
    logic [sdlp_pkg::DELAY_W-1:0]       r_delay_right;
    logic [sdlp_pkg::COEF_W-1:0]        r_coef_left;
    logic [sdlp_pkg::COEF_W-1:0]        r_coef_right;

    logic [AW-1:0] r_wr_addr;
    logic [FW-1:0] r_fill;

    sdlp_pkg::t_lane_ctl ctl;
    logic                accept;
    logic                out_free;
    logic                load;
    logic signed [sdlp_pkg::SAMPLE_W-1:0] y_left;
    logic signed [sdlp_pkg::SAMPLE_W-1:0] y_right;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain_left   <= sdlp_pkg::GAIN_RESET;
            r_gain_right  <= sdlp_pkg::GAIN_RESET;
            r_delay_left  <= sdlp_pkg::DELAY_RESET;
            r_delay_right <= sdlp_pkg::DELAY_RESET;
            r_coef_left   <= sdlp_pkg::COEF_ONE;
            r_coef_right  <= sdlp_pkg::COEF_ONE;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                sdlp_pkg::CFG_GAIN_LEFT: begin
                    r_gain_left <= i_cfg_data;
                end
                sdlp_pkg::CFG_GAIN_RIGHT: begin
                    r_gain_right <= i_cfg_data;
                end
                sdlp_pkg::CFG_DELAY_LEFT: begin
                    r_delay_left <= i_cfg_data[sdlp_pkg::DELAY_W-1:0];
                end
                sdlp_pkg::CFG_DELAY_RIGHT: begin
                    r_delay_right <= i_cfg_data[sdlp_pkg::DELAY_W-1:0];
                end
                sdlp_pkg::CFG_COEF_LEFT: begin
                    r_coef_left <= i_cfg_data;
                end
                sdlp_pkg::CFG_COEF_RIGHT: begin
                    r_coef_right <= i_cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    assign load       = (r_state == S_DONE) && out_free;
    assign o_in_stall = !((r_state == S_IDLE) || load);
    assign accept     = i_in_valid && !o_in_stall;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_DIFF;
                end
            end
            S_DIFF: begin
                n_state = S_MAC;
            end
            S_MAC: begin
                n_state = S_GAIN;
            end
            S_GAIN: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (accept) begin
                    n_state = S_DIFF;
                end else if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_addr <= '0;
            r_fill    <= '0;
        end else if (accept) begin
            if (r_wr_addr == AW'(DELAY_DEPTH - 1)) begin
                r_wr_addr <= '0;
            end else begin
                r_wr_addr <= r_wr_addr + 1'b1;
            end
            if (r_fill != FW'(DELAY_DEPTH)) begin
                r_fill <= r_fill + 1'b1;
            end
        end
    end

    always_comb begin
        ctl.accept  = accept;
        ctl.diff_en = (r_state == S_DIFF);
        ctl.mac_en  = (r_state == S_MAC);
        ctl.gain_en = (r_state == S_GAIN);
    end

    sdlp_lane #(
        .DELAY_DEPTH (DELAY_DEPTH)
    ) u_lane_left (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (ctl),
        .i_sample  (i_in_data.left_sample),
        .i_wr_addr (r_wr_addr),
        .i_fill    (r_fill),
        .i_delay   (r_delay_left),
        .i_coef    (r_coef_left),
        .i_gain    (r_gain_left),
        .o_y       (y_left)
    );

    sdlp_lane #(
        .DELAY_DEPTH (DELAY_DEPTH)
    ) u_lane_right (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (ctl),
        .i_sample  (i_in_data.right_sample),
        .i_wr_addr (r_wr_addr),
        .i_fill    (r_fill),
        .i_delay   (r_delay_right),
        .i_coef    (r_coef_right),
        .i_gain    (r_gain_right),
        .o_y       (y_right)
    );

    sdlp_merge u_merge (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (load),
        .i_left      (y_left),
        .i_right     (y_right),
        .o_free      (out_free),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

// ===== tb/stereo_delay_lowpass_panner_test.sv =====
// Self-checking testbench for the stereo delay, low-pass and gain panner.
`timescale 1ns / 1ps

module stereo_delay_lowpass_panner_test;

    import sdlp_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_A = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_B = 3'd7;
    localparam int LINE_DEPTH = DELAY_DEPTH_DEF;
    localparam int SEGMENTS = 8;
    localparam int FRAMES_PER_SEGMENT = 68;

    typedef enum logic {ROW_FRAME, ROW_WRITE} t_row_kind;

    typedef struct {
        t_row_kind               kind;
        logic [CFG_IDX_W-1:0]    index;
        logic [CFG_DATA_W-1:0]   data;
        t_in_beat                beat;
        bit                      fixed;
        t_out_beat               want;
    } t_row;

    logic                  i_clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    t_in_beat              in_beat = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    t_out_beat             out_beat;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    int send_idle_pct = 0;
    int stall_pct = 0;
    int mismatch_count = 0;

    // Shadow state of both lanes; index 0 is left, 1 is right.
    logic signed [SAMPLE_W-1:0] delay_line [2][LINE_DEPTH];
    logic [DELAY_W-1:0]         line_pos;
    longint                     lowpass_acc [2];
    logic signed [GAIN_W-1:0]   lane_gain [2];
    logic [DELAY_W-1:0]         lane_delay [2];
    logic [COEF_W-1:0]          lane_coef [2];

    t_out_beat expected_frames [$];
    t_row      directed_rows [$];
    t_out_beat head;

    stereo_delay_lowpass_panner dut (
        .i_clk       (i_clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_beat),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_beat),
        .i_cfg_wr_en (cfg_wr_en),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic longint clamp(longint v, int w);
        longint hi;
        longint lo;
        hi = (longint'(1) << (w - 1)) - 1;
        lo = -hi - 1;
        if (v > hi) return hi;
        if (v < lo) return lo;
        return v;
    endfunction

    function automatic logic signed [SAMPLE_W-1:0] lane_step(int lane,
                                                             logic signed [SAMPLE_W-1:0] x);
        logic [DELAY_W-1:0] rd;
        longint coef;
        longint diff;
        longint y;
        delay_line[lane][line_pos] = x;
        rd = line_pos - lane_delay[lane];
        coef = (lane_coef[lane] > COEF_ONE) ? longint'(COEF_ONE) : longint'(lane_coef[lane]);
        diff = longint'(delay_line[lane][rd]) * 256 - lowpass_acc[lane];
        lowpass_acc[lane] = clamp(lowpass_acc[lane] + ((diff * coef) >>> COEF_FRAC), STATE_W);
        y = clamp((lowpass_acc[lane] * longint'(lane_gain[lane])) >>> 23, SAMPLE_W);
        return y[SAMPLE_W-1:0];
    endfunction

    function automatic t_out_beat predict_frame(t_in_beat beat);
        t_out_beat r;
        r.left_out  = lane_step(0, beat.left_sample);
        r.right_out = lane_step(1, beat.right_sample);
        line_pos = line_pos + 1'b1;
        return r;
    endfunction

    function automatic void predict_config(logic [CFG_IDX_W-1:0] idx,
                                           logic [CFG_DATA_W-1:0] data);
        case (idx)
            CFG_GAIN_LEFT:   lane_gain[0] = data;
            CFG_GAIN_RIGHT:  lane_gain[1] = data;
            CFG_DELAY_LEFT:  lane_delay[0] = data[DELAY_W-1:0];
            CFG_DELAY_RIGHT: lane_delay[1] = data[DELAY_W-1:0];
            CFG_COEF_LEFT:   lane_coef[0] = data;
            CFG_COEF_RIGHT:  lane_coef[1] = data;
            default: ;
        endcase
    endfunction

    function automatic void add_frame(logic [15:0] l, logic [15:0] r, bit fixed,
                                      logic [15:0] want_l, logic [15:0] want_r);
        t_row row;
        row.kind = ROW_FRAME;
        row.index = '0;
        row.data = '0;
        row.beat.left_sample = l;
        row.beat.right_sample = r;
        row.fixed = fixed;
        row.want.left_out = want_l;
        row.want.right_out = want_r;
        directed_rows.push_back(row);
    endfunction

    function automatic void add_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        t_row row;
        row.kind = ROW_WRITE;
        row.index = idx;
        row.data = data;
        row.beat = '0;
        row.fixed = 1'b0;
        row.want = '0;
        directed_rows.push_back(row);
    endfunction

    function automatic logic [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(7))
            0: return 16'h7FFF;
            1: return 16'h8000;
            2: return 16'h0000;
            3: return 16'($urandom_range(511)) - 16'd256;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_frame(input t_in_beat beat, input bit fixed, input t_out_beat want);
        t_out_beat predicted;
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_beat  <= beat;
        do @(posedge i_clk); while (in_stall);
        predicted = predict_frame(beat);
        expected_frames.push_back(fixed ? want : predicted);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (expected_frames.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        drain();
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge i_clk);
        predict_config(idx, data);
        cfg_wr_en <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic report_mismatch(input string what, input logic [15:0] want,
                                   input logic [15:0] got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%0t: %s expected %h got %h", $realtime, what, want, got);
    endtask

    always @(posedge i_clk) begin
        out_stall <= ($urandom_range(99) < stall_pct);
    end

    always @(posedge i_clk) begin
        if (rst_n && out_valid && !out_stall) begin
            if (expected_frames.size() == 0) begin
                report_mismatch("unexpected beat", 16'h0000, out_beat.left_out);
            end else begin
                head = expected_frames.pop_front();
                if (out_beat.left_out !== head.left_out)
                    report_mismatch("left_out", head.left_out, out_beat.left_out);
                if (out_beat.right_out !== head.right_out)
                    report_mismatch("right_out", head.right_out, out_beat.right_out);
            end
        end
    end

    initial begin
        #1_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        int send_idle_by_phase [4];
        int stall_by_phase [4];
        t_row row;
        t_in_beat beat;
        int lane;
        int seg;
        int n;
        logic [CFG_DATA_W-1:0] v;

        send_idle_by_phase = '{0, 55, 0, 7};
        stall_by_phase     = '{0, 0, 55, 7};
        for (lane = 0; lane < 2; lane++) begin
            for (n = 0; n < LINE_DEPTH; n++) delay_line[lane][n] = '0;
            lowpass_acc[lane] = 0;
            lane_gain[lane] = GAIN_RESET;
            lane_delay[lane] = DELAY_RESET;
            lane_coef[lane] = COEF_ONE;
        end
        line_pos = '0;

        // With the reset settings the filter passes the sample and the gain is just below one.
        add_frame(16'h0000, 16'h0000, 1, 16'h0000, 16'h0000);
        add_frame(16'h7FFF, 16'h8000, 1, 16'h7FFE, 16'h8001);
        add_frame(16'h8000, 16'h7FFF, 1, 16'h8001, 16'h7FFE);
        add_frame(16'h0001, 16'hFFFF, 1, 16'h0000, 16'hFFFF);
        add_frame(16'h5555, 16'hAAAA, 0, 16'h0000, 16'h0000);
        add_frame(16'hAAAA, 16'h5555, 0, 16'h0000, 16'h0000);
        // Negative full-scale gain; the right lane saturates.
        add_write(CFG_GAIN_LEFT, 16'h8000);
        add_write(CFG_GAIN_RIGHT, 16'h8000);
        add_frame(16'h7FFF, 16'h8000, 1, 16'h8001, 16'h7FFF);
        // A frozen filter on the left and an over-range coefficient on the right.
        add_write(CFG_COEF_LEFT, 16'h0000);
        add_write(CFG_COEF_RIGHT, 16'hFFFF);
        add_frame(16'h8000, 16'h7FFF, 0, 16'h0000, 16'h0000);
        add_frame(16'h3039, 16'hCFC7, 0, 16'h0000, 16'h0000);
        // Longest delay reaches entries not yet written since reset.
        add_write(CFG_DELAY_LEFT, 16'h00FF);
        add_write(CFG_DELAY_RIGHT, 16'h0001);
        add_frame(16'h1234, 16'hEDCC, 0, 16'h0000, 16'h0000);
        add_frame(16'h7FFF, 16'h8000, 0, 16'h0000, 16'h0000);
        // Writes to indexes past the register list must have no effect.
        add_write(CFG_UNUSED_A, 16'hFFFF);
        add_write(CFG_UNUSED_B, 16'h0000);
        add_frame(16'h0100, 16'hFF00, 0, 16'h0000, 16'h0000);
        add_write(CFG_GAIN_LEFT, 16'h0000);
        add_write(CFG_GAIN_RIGHT, 16'h7FFF);
        add_write(CFG_COEF_LEFT, 16'h4000);
        add_write(CFG_COEF_RIGHT, 16'h8000);
        add_frame(16'h7FFF, 16'h7FFF, 0, 16'h0000, 16'h0000);
        add_frame(16'h8000, 16'h8000, 0, 16'h0000, 16'h0000);

        repeat (2) @(posedge i_clk);
        rst_n <= 1'b1;

        send_idle_pct = send_idle_by_phase[3];
        stall_pct = stall_by_phase[3];
        foreach (directed_rows[i]) begin
            row = directed_rows[i];
            if (row.kind == ROW_WRITE) begin
                write_reg(row.index, row.data);
            end else begin
                send_frame(row.beat, row.fixed, row.want);
            end
        end

        for (seg = 0; seg < SEGMENTS; seg++) begin
            for (lane = 0; lane < 2; lane++) begin
                case ($urandom_range(4))
                    0: v = 16'h7FFF;
                    1: v = 16'h8000;
                    2: v = 16'h0000;
                    default: v = 16'($urandom);
                endcase
                write_reg(lane ? CFG_GAIN_RIGHT : CFG_GAIN_LEFT, v);
                case ($urandom_range(3))
                    0: v = 16'd0;
                    1: v = 16'd255;
                    2: v = 16'($urandom_range(8, 1));
                    default: v = 16'($urandom_range(255));
                endcase
                write_reg(lane ? CFG_DELAY_RIGHT : CFG_DELAY_LEFT, v);
                case ($urandom_range(5))
                    0: v = 16'h0000;
                    1: v = COEF_ONE;
                    2: v = 16'hFFFF;
                    3: v = 16'($urandom_range(16'hFFFF, 16'h8001));
                    default: v = 16'($urandom_range(32768));
                endcase
                write_reg(lane ? CFG_COEF_RIGHT : CFG_COEF_LEFT, v);
            end
            send_idle_pct = send_idle_by_phase[seg % 4];
            stall_pct = stall_by_phase[seg % 4];
            for (n = 0; n < FRAMES_PER_SEGMENT; n++) begin
                beat.left_sample = pick_sample();
                beat.right_sample = pick_sample();
                send_frame(beat, 1'b0, '0);
            end
        end

        drain();
        repeat (16) @(posedge i_clk);
        if (mismatch_count == 0 && expected_frames.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/sdlp_pkg.sv
rtl/sdlp_lane.sv
rtl/sdlp_merge.sv
rtl/stereo_delay_lowpass_panner.sv
tb/stereo_delay_lowpass_panner_test.sv
